>>> rtl/core/spf_pkg.sv
// Shared types, constants and elaboration-time functions for the scattering phase factor core.
// No dependencies; every other file in rtl/core imports this package.
package spf_pkg;

    localparam int CORDIC_STAGES_DEF = 24;
    localparam int FRAC_BITS_DEF     = 16;

    localparam logic [63:0]        TWO_PI_Q60  = 64'h6487_ED51_10B4_611A;
    localparam logic signed [31:0] GAIN_Q30    = 32'sd652032874;
    localparam logic signed [31:0] SCALE_RESET = 32'sd65536;

    typedef enum logic [1:0] {
        REG_Q_X   = 2'd0,
        REG_Q_Y   = 2'd1,
        REG_Q_Z   = 2'd2,
        REG_SCALE = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic        valid;
        logic        last;
        logic        neg;
        logic [63:0] rem;
    } mod_bus_t;

    typedef struct packed {
        logic               valid;
        logic               last;
        logic               flip;
        logic signed [63:0] z;
    } phase_bus_t;

    typedef struct packed {
        logic               valid;
        logic               last;
        logic               flip;
        logic signed [63:0] x;
        logic signed [63:0] y;
        logic signed [63:0] z;
    } rot_bus_t;

    function automatic logic [63:0] two_pi_fixed(input int frac_bits);
        return (TWO_PI_Q60 + (64'd1 << (59 - 2 * frac_bits))) >> (60 - 2 * frac_bits);
    endfunction

    function automatic int bit_len(input logic [63:0] v);
        int n;
        n = 0;
        for (int i = 0; i < 64; i++) begin
            if (v[i]) begin
                n = i + 1;
            end
        end
        return n;
    endfunction

    function automatic logic [63:0] uquot(input logic [63:0] num, input logic [63:0] den);
        logic [64:0] rem;
        logic [63:0] quo;
        rem = '0;
        quo = '0;
        for (int i = 63; i >= 0; i--) begin
            rem = {rem[63:0], num[i]};
            if (rem >= {1'b0, den}) begin
                rem    = rem - {1'b0, den};
                quo[i] = 1'b1;
            end
        end
        return quo;
    endfunction

    // atan(2^-stage) with 61 fraction bits, truncated odd-power series
    function automatic logic signed [63:0] atan_q61(input int stage);
        logic signed [63:0] acc;
        logic [63:0]        term;
        int                 n;
        acc  = '0;
        term = '0;
        n    = 0;
        if (stage == 0) begin
            return signed'(TWO_PI_Q60 >> 2);
        end
        for (int k = 0; k < 32; k++) begin
            n = (2 * k + 1) * stage;
            if (n < 62) begin
                term = uquot(64'h2000_0000_0000_0000 >> n, 64'(2 * k + 1));
                if ((k & 1) != 0) begin
                    acc = acc - signed'(term);
                end
                else begin
                    acc = acc + signed'(term);
                end
            end
        end
        return acc;
    endfunction

endpackage

>>> rtl/core/spf_mod_cell.sv
// One restoring step of the phase reduction chain: subtract a fixed multiple of 2*pi if it fits.
// Depends on spf_pkg (mod_bus_t).
module spf_mod_cell
    import spf_pkg::*;
#(
    parameter logic [63:0] DIVISOR = 64'd1
)(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     en,
    input  mod_bus_t din,
    output mod_bus_t dout
);

    mod_bus_t bus_next;
    mod_bus_t bus_reg;

    always_comb
    begin
        bus_next = din;
        if (din.rem >= DIVISOR)
        begin
            bus_next.rem = din.rem - DIVISOR;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bus_reg <= '0;
        end
        else if (en)
        begin
            bus_reg <= bus_next;
        end
    end

    assign dout = bus_reg;

endmodule

>>> rtl/core/spf_cordic_cell.sv
// One rotation-mode CORDIC stage with its fixed shift and arctangent constant.
// Depends on spf_pkg (rot_bus_t, atan_q61).
module spf_cordic_cell
    import spf_pkg::*;
#(
    parameter int STAGE = 0
)(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     en,
    input  rot_bus_t din,
    output rot_bus_t dout
);

    localparam logic signed [63:0] ANGLE = atan_q61(STAGE);

    logic signed [63:0] xs;
    logic signed [63:0] ys;
    rot_bus_t           bus_next;
    rot_bus_t           bus_reg;

    assign xs = $signed(din.x) >>> STAGE;
    assign ys = $signed(din.y) >>> STAGE;

    always_comb
    begin
        bus_next = din;
        if (!din.z[63])
        begin
            bus_next.x = din.x - ys;
            bus_next.y = din.y + xs;
            bus_next.z = din.z - ANGLE;
        end
        else
        begin
            bus_next.x = din.x + ys;
            bus_next.y = din.y - xs;
            bus_next.z = din.z + ANGLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bus_reg <= '0;
        end
        else if (en)
        begin
            bus_reg <= bus_next;
        end
    end

    assign dout = bus_reg;

endmodule

>>> rtl/core/spf_phase.sv
// Phase front end: q.r products, sum, reduction modulo 2*pi through a chain of
// restoring cells, and folding to [-pi/2, pi/2]. Depends on spf_pkg and spf_mod_cell.
module spf_phase
    import spf_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_valid,
    input  logic signed [31:0] pos_x,
    input  logic signed [31:0] pos_y,
    input  logic signed [31:0] pos_z,
    input  logic               last_frame,
    input  logic signed [31:0] q_x,
    input  logic signed [31:0] q_y,
    input  logic signed [31:0] q_z,
    output phase_bus_t         phase
);

    localparam logic [63:0] MOD   = two_pi_fixed(FRAC_BITS);
    localparam int          MOD_W = bit_len(MOD);
    localparam int          QB    = 65 - MOD_W;
    localparam int          PH_W  = MOD_W + 1;
    localparam int          SH    = 61 - 2 * FRAC_BITS;

    localparam logic signed [PH_W-1:0] MOD_S     = PH_W'(MOD);
    localparam logic signed [PH_W-1:0] PI_S      = PH_W'(MOD >> 1);
    localparam logic signed [PH_W-1:0] HPI_S     = PH_W'(MOD >> 2);
    localparam logic signed [PH_W-1:0] NEG_HPI_S = -HPI_S;

    logic                   s1_valid_reg;
    logic                   s1_last_reg;
    logic signed [63:0]     prod_x_reg;
    logic signed [63:0]     prod_y_reg;
    logic signed [63:0]     prod_z_reg;

    logic                   s2_valid_reg;
    logic                   s2_last_reg;
    logic signed [64:0]     sum_reg;

    mod_bus_t               chain [QB+1];
    mod_bus_t               s3_reg;
    mod_bus_t               s3_next;

    logic [63:0]            rem_fix;
    logic                   s4_valid_reg;
    logic                   s4_last_reg;
    logic signed [PH_W-1:0] th4_reg;

    logic                   s5_valid_reg;
    logic                   s5_last_reg;
    logic signed [PH_W-1:0] th5_reg;
    logic signed [PH_W-1:0] th5_next;

    logic signed [PH_W-1:0] th6_next;
    logic                   flip_next;
    phase_bus_t             s6_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_reg       <= '0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
            s6_reg       <= '0;
        end
        else if (en)
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_reg       <= s3_next;
            s4_valid_reg <= chain[QB].valid;
            s5_valid_reg <= s4_valid_reg;
            s6_reg.valid <= s5_valid_reg;
            s6_reg.last  <= s5_last_reg;
            s6_reg.flip  <= flip_next;
            s6_reg.z     <= 64'(th6_next) <<< SH;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_last_reg <= last_frame;
            prod_x_reg  <= 64'(pos_x) * 64'(q_x);
            prod_y_reg  <= 64'(pos_y) * 64'(q_y);
            prod_z_reg  <= 64'(pos_z) * 64'(q_z);
            s2_last_reg <= s1_last_reg;
            sum_reg     <= 65'(prod_x_reg) + 65'(prod_y_reg) + 65'(prod_z_reg);
            s4_last_reg <= chain[QB].last;
            th4_reg     <= signed'({1'b0, rem_fix[MOD_W-1:0]});
            s5_last_reg <= s4_last_reg;
            th5_reg     <= th5_next;
        end
    end

    // reduce the magnitude, restore the sign afterwards
    always_comb
    begin
        s3_next.valid = s2_valid_reg;
        s3_next.last  = s2_last_reg;
        s3_next.neg   = sum_reg[64];
        s3_next.rem   = sum_reg[64] ? 64'(-sum_reg) : 64'(sum_reg);
    end

    assign chain[0] = s3_reg;

    for (genvar j = 0; j < QB; j++)
    begin : g_mod
        spf_mod_cell #(
            .DIVISOR (MOD << (QB - 1 - j))
        ) u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .en    (en),
            .din   (chain[j]),
            .dout  (chain[j+1])
        );
    end

    assign rem_fix = (chain[QB].neg && (chain[QB].rem != 64'd0)) ?
                     MOD - chain[QB].rem : chain[QB].rem;

    assign th5_next = (th4_reg >= PI_S) ? th4_reg - MOD_S : th4_reg;

    always_comb
    begin
        th6_next  = th5_reg;
        flip_next = 1'b0;
        if (th5_reg > HPI_S)
        begin
            th6_next  = th5_reg - PI_S;
            flip_next = 1'b1;
        end
        else if (th5_reg < NEG_HPI_S)
        begin
            th6_next  = th5_reg + PI_S;
            flip_next = 1'b1;
        end
    end

    assign phase = s6_reg;

endmodule

>>> rtl/core/scattering_phase_factor.sv
// Channel   Handshake                 Payload
// input     in_valid / in_ready       pos_x, pos_y, pos_z, last_frame
// output    out_valid / out_ready     real_part, imag_part, last_out
// config    psel, penable, pwrite     paddr, pwdata -> prdata, pready tied high
//
// One item per cycle while in_ready is high. Between input transfer and output valid an item
// passes through the 62 - 2*FRAC_BITS restoring cells of the phase reduction and the
// CORDIC_STAGES rotation cells.
// Reset clears the configuration registers (scale to 1.0) and all valid bits; no clearing pass.
// A two-entry output buffer absorbs stalls; in_ready drops only once both entries hold results.
// Depends on spf_pkg, spf_phase, spf_mod_cell and spf_cordic_cell.
module scattering_phase_factor
    import spf_pkg::*;
#(
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF,
    parameter int FRAC_BITS     = FRAC_BITS_DEF
)(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [31:0] pos_x,
    input  logic signed [31:0] pos_y,
    input  logic signed [31:0] pos_z,
    input  logic               last_frame,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] real_part,
    output logic signed [31:0] imag_part,
    output logic               last_out
);

    localparam logic signed [63:0] RND_POS = 64'sd536870912;
    localparam logic signed [63:0] RND_NEG = 64'sd536870913;

    function automatic logic signed [31:0] round_sat(input logic signed [63:0] v,
                                                     input logic neg);
        logic signed [63:0] t;
        logic signed [63:0] r;
        t = (neg ? ~v : v) + (neg ? RND_NEG : RND_POS);
        r = t >>> 30;
        if (r > 64'sd2147483647)
        begin
            return 32'sh7FFF_FFFF;
        end
        else if (r < -64'sd2147483648)
        begin
            return 32'sh8000_0000;
        end
        return r[31:0];
    endfunction

    reg_idx_t           idx;
    logic               wr;
    logic signed [31:0] q_x_reg;
    logic signed [31:0] q_y_reg;
    logic signed [31:0] q_z_reg;
    logic signed [31:0] scale_reg;
    logic signed [63:0] x0_reg;

    logic               en;
    phase_bus_t         phase;
    rot_bus_t           rot [CORDIC_STAGES+1];

    logic               os_valid_reg;
    logic               os_last_reg;
    logic signed [31:0] os_re_reg;
    logic signed [31:0] os_im_reg;

    logic               push;
    logic               pop;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic               last_reg;
    logic signed [31:0] real_reg;
    logic signed [31:0] imag_reg;
    logic               skid_v_reg;
    logic               skid_v_next;
    logic               skid_last_reg;
    logic signed [31:0] skid_re_reg;
    logic signed [31:0] skid_im_reg;

    assign idx    = reg_idx_t'(paddr[3:2]);
    assign wr     = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_x_reg   <= '0;
            q_y_reg   <= '0;
            q_z_reg   <= '0;
            scale_reg <= SCALE_RESET;
        end
        else if (wr)
        begin
            case (idx)
                REG_Q_X:   q_x_reg   <= pwdata;
                REG_Q_Y:   q_y_reg   <= pwdata;
                REG_Q_Z:   q_z_reg   <= pwdata;
                REG_SCALE: scale_reg <= pwdata;
                default:   ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_Q_X:   prdata = q_x_reg;
            REG_Q_Y:   prdata = q_y_reg;
            REG_Q_Z:   prdata = q_z_reg;
            REG_SCALE: prdata = scale_reg;
            default:   prdata = '0;
        endcase
    end

    // start vector: scale times CORDIC gain
    always_ff @(posedge clk)
    begin
        x0_reg <= 64'(scale_reg) * 64'(GAIN_Q30);
    end

    assign en       = !skid_v_reg;
    assign in_ready = en;

    spf_phase #(
        .FRAC_BITS (FRAC_BITS)
    ) u_phase (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .in_valid   (in_valid),
        .pos_x      (pos_x),
        .pos_y      (pos_y),
        .pos_z      (pos_z),
        .last_frame (last_frame),
        .q_x        (q_x_reg),
        .q_y        (q_y_reg),
        .q_z        (q_z_reg),
        .phase      (phase)
    );

    assign rot[0] = '{valid: phase.valid, last: phase.last, flip: phase.flip,
                      x: x0_reg, y: 64'sd0, z: phase.z};

    for (genvar i = 0; i < CORDIC_STAGES; i++)
    begin : g_rot
        spf_cordic_cell #(
            .STAGE (i)
        ) u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .en    (en),
            .din   (rot[i]),
            .dout  (rot[i+1])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            os_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            os_valid_reg <= rot[CORDIC_STAGES].valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            os_last_reg <= rot[CORDIC_STAGES].last;
            os_re_reg   <= round_sat(rot[CORDIC_STAGES].x, rot[CORDIC_STAGES].flip);
            os_im_reg   <= round_sat(rot[CORDIC_STAGES].y, rot[CORDIC_STAGES].flip);
        end
    end

    // output buffer: head register plus one skid entry
    assign push = en && os_valid_reg;
    assign pop  = out_valid_reg && out_ready;

    always_comb
    begin
        out_valid_next = (out_valid_reg && !pop) || skid_v_reg || push;
        skid_v_next    = skid_v_reg;
        if (pop && skid_v_reg)
        begin
            skid_v_next = 1'b0;
        end
        else if (push && out_valid_reg && !pop)
        begin
            skid_v_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            skid_v_reg    <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            skid_v_reg    <= skid_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && skid_v_reg)
        begin
            real_reg <= skid_re_reg;
            imag_reg <= skid_im_reg;
            last_reg <= skid_last_reg;
        end
        else if (push && (pop || !out_valid_reg))
        begin
            real_reg <= os_re_reg;
            imag_reg <= os_im_reg;
            last_reg <= os_last_reg;
        end
        if (push && out_valid_reg && !pop)
        begin
            skid_re_reg   <= os_re_reg;
            skid_im_reg   <= os_im_reg;
            skid_last_reg <= os_last_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign real_part = real_reg;
    assign imag_part = imag_reg;
    assign last_out  = last_reg;

`ifndef SYNTHESIS
    a_skid_needs_head: assert property (@(posedge clk) disable iff (!rst_n)
        skid_v_reg |-> out_valid_reg)
        else $error("skid entry held without a head result");

    a_skid_drains_on_pop: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(skid_v_reg) |-> $past(out_valid && out_ready))
        else $error("skid entry left without an output transfer");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(in_ready) |-> $past(push && out_valid_reg && !pop))
        else $error("input stalled without a blocked result");
`endif

endmodule

>>> dv/scattering_phase_factor_tb.sv
// Testbench for the scattering phase factor core: APB setup, streamed atom positions and a
// scoreboard class that predicts scale*cos(q.r) and scale*sin(q.r) bit for bit.
// Depends on spf_pkg and the scattering_phase_factor RTL.
`timescale 1ns / 100ps

typedef struct packed {
    logic signed [31:0] re;
    logic signed [31:0] im;
    logic               last;
} phase_factor_t;

class phase_factor_book;
    localparam int STAGES = spf_pkg::CORDIC_STAGES_DEF;
    localparam int FB     = spf_pkg::FRAC_BITS_DEF;

    phase_factor_t      expected_q[$];
    logic signed [31:0] q_x_r, q_y_r, q_z_r, scale_r;
    logic signed [63:0] turn, half_turn, quarter_turn;
    logic signed [63:0] angle_tab[STAGES];
    int                 errors;
    int                 noted;
    int                 checked;

    function new();
        logic signed [63:0] acc, term, den;
        int                 k;
        turn = signed'((spf_pkg::TWO_PI_Q60 + (64'd1 << (59 - 2 * FB))) >> (60 - 2 * FB));
        half_turn    = turn >>> 1;
        quarter_turn = turn >>> 2;
        angle_tab[0] = signed'(spf_pkg::TWO_PI_Q60 >> 2);
        for (int i = 1; i < STAGES; i++) begin
            acc = 0;
            for (k = 0; (2 * k + 1) * i < 62; k++) begin
                den  = 2 * k + 1;
                term = ((64'sd1 <<< 61) >>> ((2 * k + 1) * i)) / den;
                acc  = (k % 2 == 1) ? acc - term : acc + term;
            end
            angle_tab[i] = acc;
        end
        q_x_r   = 0;
        q_y_r   = 0;
        q_z_r   = 0;
        scale_r = spf_pkg::SCALE_RESET;
        errors  = 0;
        noted   = 0;
        checked = 0;
    endfunction

    function void set_reg(spf_pkg::reg_idx_t idx, logic [31:0] val);
        case (idx)
            spf_pkg::REG_Q_X:   q_x_r   = val;
            spf_pkg::REG_Q_Y:   q_y_r   = val;
            spf_pkg::REG_Q_Z:   q_z_r   = val;
            spf_pkg::REG_SCALE: scale_r = val;
            default: ;
        endcase
    endfunction

    function logic signed [63:0] wrap_turn(logic signed [31:0] pos, logic signed [31:0] q);
        logic signed [63:0] a, b, r;
        a = pos;
        b = q;
        r = (a * b) % turn;
        if (r < 0)
            r = r + turn;
        return r;
    endfunction

    function logic signed [31:0] round_sat(logic signed [63:0] v, bit flip);
        logic signed [63:0] r;
        if (flip)
            v = -v;
        r = (v + (64'sd1 <<< 29)) >>> 30;
        if (r > 64'sd2147483647)
            r = 64'sd2147483647;
        else if (r < -64'sd2147483648)
            r = -64'sd2147483648;
        return r[31:0];
    endfunction

    function void note_input(logic signed [31:0] px, logic signed [31:0] py,
                             logic signed [31:0] pz, logic lf);
        logic signed [63:0] th, x, y, z, xs, ys, sc;
        bit                 flip;
        phase_factor_t      res;
        flip = 0;
        th = wrap_turn(px, q_x_r) + wrap_turn(py, q_y_r) + wrap_turn(pz, q_z_r);
        while (th >= turn)
            th = th - turn;
        if (th >= half_turn)
            th = th - turn;
        if (th > quarter_turn) begin
            th   = th - half_turn;
            flip = 1;
        end
        else if (th < -quarter_turn) begin
            th   = th + half_turn;
            flip = 1;
        end
        z  = th <<< (61 - 2 * FB);
        sc = scale_r;
        x  = sc * 64'(spf_pkg::GAIN_Q30);
        y  = 0;
        for (int i = 0; i < STAGES; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0) begin
                x = x - ys;
                y = y + xs;
                z = z - angle_tab[i];
            end
            else begin
                x = x + ys;
                y = y - xs;
                z = z + angle_tab[i];
            end
        end
        res.re   = round_sat(x, flip);
        res.im   = round_sat(y, flip);
        res.last = lf;
        expected_q.push_back(res);
        noted++;
    endfunction

    function void check_result(logic signed [31:0] re, logic signed [31:0] im, logic lo);
        phase_factor_t want;
        if (expected_q.size() == 0) begin
            $error("result with no pending transfer: real_part %0d imag_part %0d", re, im);
            errors++;
            return;
        end
        want = expected_q.pop_front();
        checked++;
        if (re !== want.re) begin
            $error("real_part mismatch: expected %0d, actual %0d", want.re, re);
            errors++;
        end
        if (im !== want.im) begin
            $error("imag_part mismatch: expected %0d, actual %0d", want.im, im);
            errors++;
        end
        if (lo !== want.last) begin
            $error("last_out mismatch: expected %0d, actual %0d", want.last, lo);
            errors++;
        end
    endfunction

    function int pending();
        return expected_q.size();
    endfunction
endclass

module scattering_phase_factor_tb;
    import spf_pkg::*;

    localparam int LATENCY   = 70 - 2 * FRAC_BITS_DEF + CORDIC_STAGES_DEF;
    localparam int HOLD_LEN  = 300;
    localparam int LIMIT     = 600000;
    localparam int HALF_PI_X = 102944;

    logic               clk;
    logic               rst_n      = 1'b0;
    logic               psel       = 1'b0;
    logic               penable    = 1'b0;
    logic               pwrite     = 1'b0;
    logic [3:0]         paddr      = '0;
    logic [31:0]        pwdata     = '0;
    logic [31:0]        prdata;
    logic               pready;
    logic               in_valid   = 1'b0;
    logic               in_ready;
    logic signed [31:0] pos_x      = '0;
    logic signed [31:0] pos_y      = '0;
    logic signed [31:0] pos_z      = '0;
    logic               last_frame = 1'b0;
    logic               out_valid;
    logic               out_ready  = 1'b0;
    logic signed [31:0] real_part;
    logic signed [31:0] imag_part;
    logic               last_out;

    phase_factor_book book;
    int               idle_pct  = 0;
    int               stall_pct = 0;
    bit               long_hold = 0;
    int               hold_count = 0;
    int               cycles = 0;
    int               settings = 0;

    scattering_phase_factor u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .pos_x      (pos_x),
        .pos_y      (pos_y),
        .pos_z      (pos_z),
        .last_frame (last_frame),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .real_part  (real_part),
        .imag_part  (imag_part),
        .last_out   (last_out)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        book = new();
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("FAIL scattering_phase_factor");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
            book.note_input(pos_x, pos_y, pos_z, last_frame);
        if (rst_n && out_valid && out_ready)
            book.check_result(real_part, imag_part, last_out);
    end

    // hold off the output for a long stretch when asked, else stall at random
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else if (long_hold && hold_count < HOLD_LEN)
        begin
            out_ready  <= 1'b0;
            hold_count <= hold_count + 1;
        end
        else
        begin
            out_ready <= ($urandom_range(99) >= stall_pct);
            if (!long_hold)
                hold_count <= 0;
        end
    end

    task automatic apb_write(input reg_idx_t idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        book.set_reg(idx, val);
        @(posedge clk);
    endtask

    task automatic set_config(input logic [31:0] qx, input logic [31:0] qy,
                              input logic [31:0] qz, input logic [31:0] sc);
        apb_write(REG_Q_X, qx);
        apb_write(REG_Q_Y, qy);
        apb_write(REG_Q_Z, qz);
        apb_write(REG_SCALE, sc);
        settings++;
    endtask

    task automatic send_item(input logic signed [31:0] px, input logic signed [31:0] py,
                             input logic signed [31:0] pz, input logic lf);
        if ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < idle_pct);
        end
        in_valid   <= 1'b1;
        pos_x      <= px;
        pos_y      <= py;
        pos_z      <= pz;
        last_frame <= lf;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (book.pending() != 0);
    endtask

    function automatic logic signed [31:0] random_pos();
        logic signed [31:0] v;
        case ($urandom_range(9))
            6, 7:
            begin
                v = $urandom_range(262143);
                v = v - 131072;
            end
            8:
            begin
                case ($urandom_range(4))
                    0: v = 32'sh8000_0000;
                    1: v = 32'sh7FFF_FFFF;
                    2: v = 0;
                    3: v = 1;
                    default: v = -1;
                endcase
            end
            9:
            begin
                v = $urandom_range(8) * HALF_PI_X;
                v = v + $urandom_range(4) - 2;
                if ($urandom_range(1))
                    v = -v;
            end
            default: v = $urandom;
        endcase
        return v;
    endfunction

    task automatic random_items(input int count);
        repeat (count)
            send_item(random_pos(), random_pos(), random_pos(), 1'($urandom_range(1)));
    endtask

    function automatic logic [31:0] small_q();
        logic signed [31:0] v;
        v = $urandom_range(524287);
        return v - 262144;
    endfunction

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: zero q, unit scale
        send_item(0, 0, 0, 1'b0);
        send_item(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b1);
        send_item(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 1'b0);
        send_item(-1, 1, 32'sh5555_5555, 1'b1);
        drain();

        // unit q along x: walk the quadrant boundaries
        set_config(32'd65536, 32'd0, 32'd0, 32'd65536);
        send_item(HALF_PI_X, 0, 0, 1'b0);
        send_item(-HALF_PI_X, 0, 0, 1'b0);
        send_item(HALF_PI_X + 1, 0, 0, 1'b1);
        send_item(2 * HALF_PI_X, 0, 0, 1'b0);
        send_item(-2 * HALF_PI_X, 0, 0, 1'b0);
        send_item(3 * HALF_PI_X, 0, 0, 1'b1);
        send_item(4 * HALF_PI_X, 0, 0, 1'b0);
        send_item(32'sh7FFF_FFFF, 0, 0, 1'b1);
        drain();

        // extreme q and most negative scale drive saturation
        set_config(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_item(0, 0, 0, 1'b0);
        send_item(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000, 1'b1);
        send_item(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b0);
        send_item(HALF_PI_X, HALF_PI_X, 0, 1'b1);
        drain();

        set_config(32'h7FFF_FFFF, 32'h1234_5678, 32'hFEDC_BA98, 32'h7FFF_FFFF);
        send_item(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 1'b0);
        send_item(HALF_PI_X, -1, 1, 1'b1);
        drain();

        // zero scale
        set_config($urandom, $urandom, $urandom, 32'd0);
        send_item($urandom, $urandom, $urandom, 1'b1);
        send_item(32'sh7FFF_FFFF, 32'sh8000_0000, 0, 1'b0);
        send_item(random_pos(), random_pos(), random_pos(), 1'b1);
        drain();

        idle_pct  = 0;
        stall_pct = 0;
        set_config($urandom, $urandom, $urandom, $urandom);
        random_items(250);
        drain();

        idle_pct  = 86;
        stall_pct = 0;
        set_config(small_q(), small_q(), small_q(), 32'd65536);
        random_items(250);
        drain();

        idle_pct  = 0;
        stall_pct = 86;
        set_config($urandom, $urandom, $urandom, 32'h7FFF_FFFF);
        random_items(250);
        drain();

        idle_pct  = 37;
        stall_pct = 37;
        set_config($urandom, small_q(), $urandom, 32'h8000_0000);
        random_items(250);
        drain();

        // fill the pipeline and output buffer behind a long output hold
        idle_pct  = 0;
        stall_pct = 0;
        set_config($urandom, $urandom, $urandom, $urandom);
        long_hold = 1;
        random_items(200);
        drain();
        long_hold = 0;

        repeat (LATENCY + 10) @(posedge clk);
        if (book.pending() != 0)
        begin
            $error("%0d expected results never arrived", book.pending());
            book.errors++;
        end
        $display("Run covered %0d input transfers and %0d checked results over %0d settings,",
                 book.noted, book.checked, settings + 1);
        $display("with quadrant edges, saturation, zero scale, idle gaps and a long output hold.");
        if (book.errors == 0)
            $display("PASS scattering_phase_factor");
        else
            $display("FAIL scattering_phase_factor");
        $finish;
    end

endmodule
